@@ hdl/stereo_linear_resampler_defines.svh @@
// Assertion macros used by the resampler top level.
`ifndef STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_DEFINES_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define SRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in a cycle implies the consequent in the next cycle.
`define SRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/srs_pkg.sv @@
// Shared types, constants and functions of the stereo resampler.
package srs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W   = 21;
   localparam int PHASE_W  = 22;
   localparam int VOL_W    = 7;
   localparam int GAIN_W   = 9;
   localparam int INDEX_W  = 2;

   localparam logic [PHASE_W-1:0] ONE_PHASE = 22'h010000;
   localparam logic [STEP_W-1:0]  MIN_STEP  = 21'd1024;
   localparam logic [STEP_W-1:0]  RESET_STEP = 21'h010000;
   localparam logic [GAIN_W-1:0]  UNITY_GAIN = 9'd256;
   localparam logic [VOL_W-1:0]   MAX_VOLUME = 7'd100;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
   localparam logic [INDEX_W-1:0] REG_VOLUME     = 2'd1;
   localparam logic [INDEX_W-1:0] REG_MUTE       = 2'd2;

   typedef struct packed {
      logic skip;   // store the frame and drop the phase, no output
      logic load;   // capture the current frame
      logic mul;    // form the interpolation products, advance the phase
      logic scale;  // add to the previous sample and apply the gain
      logic emit;   // load the output register
   } srs_cmd_type;

   typedef struct packed {
      logic phase_ge_one;
      logic out_free;
   } srs_status_type;

   // Gain in 1/256 units: floor(min(vol,100) * 256 / 100).
   // 256/100 = 64/25, and 41944 / 2^20 approximates 1/25 closely enough
   // that the floor is exact for every product up to 6400.
   function automatic logic [GAIN_W-1:0] volume_to_gain(input logic [VOL_W-1:0] vol);
      logic [VOL_W-1:0] v;
      logic [22:0]      p;
      v = (vol > MAX_VOLUME) ? MAX_VOLUME : vol;
      p = 23'(v) * 23'd41944;
      return p[22:14];
   endfunction

endpackage

@@ hdl/stereo_linear_resampler.sv @@
// Top level of the stereo linear-interpolation resampler.
//
// The resampler takes one signed 16-bit stereo frame per input item and
// emits zero or more interpolated stereo frames per item, one output item for
// each position of a 6.16 phase accumulator below one; tlast marks the final
// output item caused by an input. Each output is prev + floor((cur - prev) *
// phase / 65536), then scaled by floor(volume * 256 / 100) / 256 with a floor
// shift, or zero while mute is set. The phase step is clamped to at least 1024
// at write time, so one input yields at most 64 outputs. An input that yields
// no output is taken without starting a run; for an input with outputs, each
// output frame passes through one interpolation multiply, one gain multiply
// and one load of the output register, driven in turn by the sequencer, and
// the load waits while the output register still holds an untaken item.
// The output register lets the next input item be accepted while the last
// output item of the previous one is still waiting. Configuration writes are
// registered and should only be made while the block is idle.
module stereo_linear_resampler
   import srs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input items.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // left_in [15:0], right_in [31:16]
   // Output items.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // left_out [15:0], right_out [31:16]
   output logic                 rsp_tlast,   // last_of_run
   // Configuration writes.
   input  logic                 csr_wr_en,
   input  logic [INDEX_W-1:0]   csr_index,
   input  logic [STEP_W-1:0]    csr_wdata
);

`include "stereo_linear_resampler_defines.svh"

   // Configuration registers. The volume is kept as its gain factor.
   logic [STEP_W-1:0] step_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic              mute_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= RESET_STEP;
         gain_ff <= UNITY_GAIN;
         mute_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PHASE_STEP: begin
               step_ff <= (csr_wdata < MIN_STEP) ? MIN_STEP : csr_wdata;
            end
            REG_VOLUME: begin
               gain_ff <= volume_to_gain(csr_wdata[VOL_W-1:0]);
            end
            REG_MUTE: begin
               mute_ff <= csr_wdata[0];
            end
            default: begin
               // Writes to unknown indexes are ignored.
            end
         endcase
      end
   end

   srs_cmd_type    cmd;
   srs_status_type status;
   logic signed [SAMPLE_W-1:0] left_out, right_out;

   // The sequencer walks each output frame through the datapath.
   srs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the phase, the frame history and the output register.
   srs_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .step        (step_ff),
      .gain        (gain_ff),
      .mute        (mute_ff),
      .left_in     (req_tdata[15:0]),
      .right_in    (req_tdata[31:16]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .left_out    (left_out),
      .right_out   (right_out),
      .last_of_run (rsp_tlast)
   );

   assign rsp_tdata = {right_out, left_out};

   // At most one datapath command is issued in any cycle.
   `SRS_ASSERT_SAME(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd), "several commands at once")
   // The output register is only loaded when it is free.
   `SRS_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, status.out_free, "output overwritten")
   // An item that starts a run blocks further input until the run ends.
   `SRS_ASSERT_NEXT(a_run_blocks, clock, reset, req_tvalid && req_tready && !status.phase_ge_one, !req_tready, "input taken during a run")
   // The last output of a run returns the sequencer to accepting input.
   `SRS_ASSERT_NEXT(a_run_ends, clock, reset, cmd.emit && status.phase_ge_one, req_tready, "run did not end")

endmodule

@@ hdl/srs_ctrl.sv @@
// Sequencer of the resampler: steps each output frame through the datapath.
module srs_ctrl
   import srs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  srs_status_type status,
   output srs_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_SCALE = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (status.phase_ge_one) begin
                  cmd.skip = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.phase_ge_one ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/srs_dpath.sv @@
// Datapath of the resampler: phase, frame history, multipliers, output register.
module srs_dpath
   import srs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  srs_cmd_type                cmd,
   output srs_status_type             status,
   input  logic [STEP_W-1:0]          step,
   input  logic [GAIN_W-1:0]          gain,
   input  logic                       mute,
   input  logic signed [SAMPLE_W-1:0] left_in,
   input  logic signed [SAMPLE_W-1:0] right_in,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [SAMPLE_W-1:0] left_out,
   output logic signed [SAMPLE_W-1:0] right_out,
   output logic                       last_of_run
);

   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic signed [SAMPLE_W-1:0]  prev_l_ff, prev_r_ff, cur_l_ff, cur_r_ff;
   logic signed [33:0]          prod_l_ff, prod_r_ff;
   logic signed [25:0]          scl_l_ff, scl_r_ff;
   logic signed [SAMPLE_W-1:0]  out_l_ff, out_r_ff;
   logic                        out_last_ff;
   logic                        out_valid_ff;

   logic                        ge_one;
   logic signed [SAMPLE_W:0]    diff_l, diff_r;
   logic signed [SAMPLE_W:0]    frac;
   logic signed [SAMPLE_W-1:0]  smp_l, smp_r;
   logic signed [GAIN_W:0]      geff;
   logic                        finish;

   assign ge_one = (phase_ff >= ONE_PHASE);
   assign status.phase_ge_one = ge_one;
   assign status.out_free     = !out_valid_ff || out_ready;

   assign diff_l = (SAMPLE_W+1)'(cur_l_ff) - (SAMPLE_W+1)'(prev_l_ff);
   assign diff_r = (SAMPLE_W+1)'(cur_r_ff) - (SAMPLE_W+1)'(prev_r_ff);
   assign frac   = $signed({1'b0, phase_ff[SAMPLE_W-1:0]});

   // Floor shift by 16 of the product; the sum stays in range by construction.
   assign smp_l = prev_l_ff + prod_l_ff[31:16];
   assign smp_r = prev_r_ff + prod_r_ff[31:16];
   assign geff  = mute ? '0 : $signed({1'b0, gain});

   assign finish = cmd.skip || (cmd.emit && ge_one);

   always_comb begin
      phase_in = phase_ff;
      if (cmd.mul) begin
         phase_in = phase_ff + PHASE_W'(step);
      end else if (finish) begin
         phase_in = phase_ff - ONE_PHASE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (cmd.skip) begin
            prev_l_ff <= left_in;
            prev_r_ff <= right_in;
         end else if (cmd.emit && ge_one) begin
            prev_l_ff <= cur_l_ff;
            prev_r_ff <= cur_r_ff;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_l_ff <= left_in;
         cur_r_ff <= right_in;
      end
      if (cmd.mul) begin
         prod_l_ff <= 34'(diff_l) * 34'(frac);
         prod_r_ff <= 34'(diff_r) * 34'(frac);
      end
      if (cmd.scale) begin
         scl_l_ff <= 26'(smp_l) * 26'(geff);
         scl_r_ff <= 26'(smp_r) * 26'(geff);
      end
      if (cmd.emit) begin
         out_l_ff    <= scl_l_ff[23:8];
         out_r_ff    <= scl_r_ff[23:8];
         out_last_ff <= ge_one;
      end
   end

   assign out_valid   = out_valid_ff;
   assign left_out    = out_l_ff;
   assign right_out   = out_r_ff;
   assign last_of_run = out_last_ff;

endmodule
